/* design/bdla_pkg.sv */
// Shared types and constants for the bob line-averaging deinterlacer.
package bdla_pkg;

    localparam int PIX_W    = 8;
    localparam int ROW_W    = 11;
    localparam int COLUMN_W = 12;
    localparam int LL_W     = 13;
    localparam int FL_W     = 11;
    localparam int PADDR_W  = 4;

    // register index, taken from paddr[3:2]
    localparam logic [1:0] REG_LINE_LENGTH = 2'd0;
    localparam logic [1:0] REG_FIELD_LINES = 2'd1;
    localparam logic [1:0] REG_TOP_FIELD   = 2'd2;

    localparam logic [LL_W-1:0] LINE_LENGTH_RST = 13'd1920;
    localparam logic [FL_W-1:0] FIELD_LINES_RST = 11'd540;

    // one accepted field pixel, ready for the result sequencer
    typedef struct packed {
        logic [PIX_W-1:0]    pix;
        logic [PIX_W-1:0]    prev;
        logic [COLUMN_W-1:0] column;
        logic [ROW_W-1:0]    row;
        logic                has_avg;
        logic                has_dup;
        logic                end_frame;
    } item_t;

endpackage

/* design/bdla_front.sv */
// Input stage: column/line counters, previous-line memory and item register.
module bdla_front #(
    parameter int MAX_LINE_LENGTH = 4096,
    parameter int MAX_FIELD_LINES = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [bdla_pkg::PIX_W-1:0]   s_tdata,   // [7:0] pixel_in
    input  logic [bdla_pkg::LL_W-1:0]    line_length,
    input  logic [bdla_pkg::FL_W-1:0]    field_lines,
    input  logic                         top_field,
    output logic                         item_valid,
    output bdla_pkg::item_t              item,
    input  logic                         item_take
);
    import bdla_pkg::*;

    localparam int COL_W     = $clog2(MAX_LINE_LENGTH);
    localparam int CMP_W     = COL_W + 1;
    localparam int LINE_W    = ($clog2(MAX_FIELD_LINES) > 0) ? $clog2(MAX_FIELD_LINES) : 1;
    localparam int LCMP_W    = LINE_W + 1;

    logic [PIX_W-1:0] mem [MAX_LINE_LENGTH];

    logic [COL_W-1:0]  col_reg, col_next;
    logic [LINE_W-1:0] line_reg, line_next;
    logic              item_valid_reg, item_valid_next;
    logic [PIX_W-1:0]  prev_reg;
    logic [PIX_W-1:0]  pix_reg;
    logic [COLUMN_W-1:0] column_reg;
    logic [ROW_W-1:0]  row_reg;
    logic              has_avg_reg, has_dup_reg, end_frame_reg;

    logic [13:0]       len_wide;
    logic [12:0]       lines_wide;
    logic [CMP_W-1:0]  len_eff, col_inc;
    logic [LCMP_W-1:0] lines_eff, line_inc;
    logic              end_line, last_line, accept;

    assign s_tready = !item_valid_reg || item_take;
    assign accept   = s_tvalid && s_tready;

    // effective lengths, clamped to 1..max
    always_comb begin
        if (line_length == '0) begin
            len_wide = 14'd1;
        end else if ({1'b0, line_length} > 14'(MAX_LINE_LENGTH)) begin
            len_wide = 14'(MAX_LINE_LENGTH);
        end else begin
            len_wide = {1'b0, line_length};
        end
        if (field_lines == '0) begin
            lines_wide = 13'd1;
        end else if ({2'b00, field_lines} > 13'(MAX_FIELD_LINES)) begin
            lines_wide = 13'(MAX_FIELD_LINES);
        end else begin
            lines_wide = {2'b00, field_lines};
        end
    end

    assign len_eff   = CMP_W'(len_wide);
    assign lines_eff = LCMP_W'(lines_wide);
    assign col_inc   = {1'b0, col_reg} + CMP_W'(1);
    assign line_inc  = {1'b0, line_reg} + LCMP_W'(1);
    // a counter at or past a shrunk limit wraps after this pixel
    assign end_line  = col_inc >= len_eff;
    assign last_line = line_inc >= lines_eff;

    always_comb begin
        col_next  = col_reg;
        line_next = line_reg;
        if (accept) begin
            if (end_line) begin
                col_next  = '0;
                line_next = last_line ? '0 : line_inc[LINE_W-1:0];
            end else begin
                col_next  = col_inc[COL_W-1:0];
            end
        end
        item_valid_next = accept || (item_valid_reg && !item_take);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg        <= '0;
            line_reg       <= '0;
            item_valid_reg <= 1'b0;
        end else begin
            col_reg        <= col_next;
            line_reg       <= line_next;
            item_valid_reg <= item_valid_next;
        end
    end

    // read-first line memory: old pixel of this column comes out registered
    always_ff @(posedge aclk) begin
        if (accept) begin
            prev_reg     <= mem[col_reg];
            mem[col_reg] <= s_tdata;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            pix_reg       <= s_tdata;
            column_reg    <= COLUMN_W'(col_reg);
            row_reg       <= ROW_W'({line_reg, ~top_field});
            has_avg_reg   <= line_reg != '0;
            has_dup_reg   <= top_field && last_line;
            end_frame_reg <= end_line && last_line;
        end
    end

    assign item_valid     = item_valid_reg;
    assign item.pix       = pix_reg;
    assign item.prev      = prev_reg;
    assign item.column    = column_reg;
    assign item.row       = row_reg;
    assign item.has_avg   = has_avg_reg;
    assign item.has_dup   = has_dup_reg;
    assign item.end_frame = end_frame_reg;

endmodule

/* design/bdla_emit.sv */
// Result sequencer: copy, average and duplicate pixels into the output register.
module bdla_emit (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              item_valid,
    input  bdla_pkg::item_t                   item,
    output logic                              item_take,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [31:0]                       m_tdata,  // [10:0] out_row, [22:11] out_column,
                                                        // [30:23] pixel_out, [31] zero
    output logic                              m_tlast,  // last_of_run
    output logic                              m_tuser   // frame_done
);
    import bdla_pkg::*;

    typedef enum logic [2:0] {
        PH_COPY = 3'b001,
        PH_AVG  = 3'b010,
        PH_DUP  = 3'b100
    } phase_t;

    phase_t              phase_reg, phase_next, phase_after;
    logic                m_valid_reg, m_valid_next;
    logic [ROW_W-1:0]    row_reg, row_sel;
    logic [COLUMN_W-1:0] column_reg;
    logic [PIX_W-1:0]    pix_reg, pix_sel;
    logic                last_reg, done_reg;
    logic                more, load;
    logic [PIX_W:0]      avg_sum;

    assign avg_sum = {1'b0, item.prev} + {1'b0, item.pix} + (PIX_W+1)'(1);
    assign load    = item_valid && (!m_valid_reg || m_tready);

    always_comb begin
        case (phase_reg)
            PH_COPY: begin
                row_sel     = item.row;
                pix_sel     = item.pix;
                more        = item.has_avg || item.has_dup;
                phase_after = item.has_avg ? PH_AVG : PH_DUP;
            end
            PH_AVG: begin
                row_sel     = item.row - ROW_W'(1);
                pix_sel     = avg_sum[PIX_W:1];
                more        = item.has_dup;
                phase_after = PH_DUP;
            end
            PH_DUP: begin
                row_sel     = item.row + ROW_W'(1);
                pix_sel     = item.pix;
                more        = 1'b0;
                phase_after = PH_COPY;
            end
            default: begin
                row_sel     = item.row;
                pix_sel     = item.pix;
                more        = 1'b0;
                phase_after = PH_COPY;
            end
        endcase
        item_take    = load && !more;
        phase_next   = phase_reg;
        if (load) begin
            phase_next = more ? phase_after : PH_COPY;
        end
        m_valid_next = load || (m_valid_reg && !m_tready);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_COPY;
            m_valid_reg <= 1'b0;
        end else begin
            phase_reg   <= phase_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            row_reg    <= row_sel;
            column_reg <= item.column;
            pix_reg    <= pix_sel;
            last_reg   <= !more;
            done_reg   <= !more && item.end_frame;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {1'b0, pix_reg, column_reg, row_reg};
    assign m_tlast  = last_reg;
    assign m_tuser  = done_reg;

endmodule

/* design/bob_deinterlace_line_average_core.sv */
// Bob deinterlacer top level: a field pixel enters per cycle while the sequencer takes it, and its
// one to three frame pixels leave one per cycle while the receiver is ready; a pixel normally gives
// two (copy and average) and a pixel of the top field's last line three, all through the single
// output port of the result register, which an accepted pixel reaches through the item register.
// Registers (APB, byte address): 0x0 line_length, 0x4 field_lines, 0x8 top_field; write
// them only while no pixel is in flight.
module bob_deinterlace_line_average_core #(
    parameter int MAX_LINE_LENGTH = 4096,
    parameter int MAX_FIELD_LINES = 1024
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [7:0]                   s_tdata,   // [7:0] pixel_in
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [31:0]                  m_tdata,   // [10:0] out_row, [22:11] out_column,
                                                    // [30:23] pixel_out, [31] zero
    output logic                         m_tlast,   // last_of_run
    output logic                         m_tuser,   // frame_done
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [bdla_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                  pwdata,
    output logic [31:0]                  prdata,
    output logic                         pready
);
    import bdla_pkg::*;

    logic [LL_W-1:0] line_length_reg;
    logic [FL_W-1:0] field_lines_reg;
    logic            top_field_reg;
    logic            cfg_wr;
    logic            item_valid, item_take;
    item_t           item;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            line_length_reg <= LINE_LENGTH_RST;
            field_lines_reg <= FIELD_LINES_RST;
            top_field_reg   <= 1'b1;
        end else if (cfg_wr) begin
            case (paddr[3:2])
                REG_LINE_LENGTH: line_length_reg <= pwdata[LL_W-1:0];
                REG_FIELD_LINES: field_lines_reg <= pwdata[FL_W-1:0];
                REG_TOP_FIELD:   top_field_reg   <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[3:2])
            REG_LINE_LENGTH: prdata = 32'(line_length_reg);
            REG_FIELD_LINES: prdata = 32'(field_lines_reg);
            REG_TOP_FIELD:   prdata = 32'(top_field_reg);
            default:         prdata = '0;
        endcase
    end

    bdla_front #(
        .MAX_LINE_LENGTH (MAX_LINE_LENGTH),
        .MAX_FIELD_LINES (MAX_FIELD_LINES)
    ) u_front (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .line_length (line_length_reg),
        .field_lines (field_lines_reg),
        .top_field   (top_field_reg),
        .item_valid  (item_valid),
        .item        (item),
        .item_take   (item_take)
    );

    bdla_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .item_valid (item_valid),
        .item       (item),
        .item_take  (item_take),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tlast    (m_tlast),
        .m_tuser    (m_tuser)
    );

endmodule

/* design/bdla_checker.sv */
// Port-level checks for the deinterlacer core, bound to the top level.
module bdla_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [31:0] m_tdata,
    input logic        m_tlast,
    input logic        m_tuser,
    input logic        pready
);

    // a stalled result holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast)
            && $stable(m_tuser))
        else $error("result changed while stalled");

    // frame end is always the last result of its pixel
    a_done_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser |-> m_tlast)
        else $error("frame_done without last_of_run");

    // nothing leaves right after reset
    a_reset_quiet: assert property (@(posedge aclk)
        $past(!aresetn) |-> !m_tvalid)
        else $error("result valid after reset");

    // spare tdata bit is zero and the config port never waits
    a_pad_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        pready && (!m_tvalid || !m_tdata[31]))
        else $error("pready low or tdata pad bit set");

endmodule

bind bob_deinterlace_line_average_core bdla_checker u_bdla_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser),
    .pready   (pready)
);

/* test/tb.sv */
// Self-checking testbench for the bob line-averaging deinterlacer core.
module tb;
    import bdla_pkg::*;

    localparam int MAX_LINE  = 4096;
    localparam int MAX_LINES = 1024;

    typedef struct packed {
        logic [ROW_W-1:0]    row;
        logic [COLUMN_W-1:0] column;
        logic [PIX_W-1:0]    pix;
        logic                last;
        logic                done;
    } frame_pixel_t;

    typedef enum int {RX_READY, RX_RANDOM, RX_BURSTY} rx_mode_t;

    // Predicts the frame pixels produced by each field pixel and checks the output stream.
    class deint_scoreboard;
        logic [LL_W-1:0]  line_length;
        logic [FL_W-1:0]  field_lines;
        logic             top_field;
        logic [PIX_W-1:0] prev_line [MAX_LINE];
        int unsigned      column_count;
        int unsigned      line_count;
        frame_pixel_t     expected_q[$];
        int               errors;

        function new();
            line_length  = LINE_LENGTH_RST;
            field_lines  = FIELD_LINES_RST;
            top_field    = 1'b1;
            column_count = 0;
            line_count   = 0;
            errors       = 0;
            foreach (prev_line[i]) prev_line[i] = '0;
        endfunction

        function void write_register(logic [1:0] index, logic [31:0] value);
            case (index)
                REG_LINE_LENGTH: line_length = value[LL_W-1:0];
                REG_FIELD_LINES: field_lines = value[FL_W-1:0];
                REG_TOP_FIELD:   top_field   = value[0];
                default: ;
            endcase
        endfunction

        function int unsigned clamp(int unsigned v, int unsigned hi);
            if (v < 1) return 1;
            if (v > hi) return hi;
            return v;
        endfunction

        function void push_pixel(int unsigned row, logic [PIX_W-1:0] pix, bit last, bit done);
            frame_pixel_t r;
            r.row    = row[ROW_W-1:0];
            r.column = column_count[COLUMN_W-1:0];
            r.pix    = pix;
            r.last   = last;
            r.done   = done;
            expected_q.push_back(r);
        endfunction

        function void note_pixel(logic [PIX_W-1:0] pix);
            int unsigned len, lines, kept_row, n;
            bit end_line, last_line, end_frame, has_avg, has_dup;
            logic [PIX_W:0] sum;
            len       = clamp(line_length, MAX_LINE);
            lines     = clamp(field_lines, MAX_LINES);
            kept_row  = 2 * line_count + (top_field ? 0 : 1);
            end_line  = (column_count + 1 >= len);
            last_line = (line_count + 1 >= lines);
            end_frame = end_line && last_line;
            has_avg   = (line_count >= 1);
            has_dup   = top_field && last_line;
            n         = 1 + has_avg + has_dup;
            sum       = {1'b0, prev_line[column_count]} + {1'b0, pix} + (PIX_W+1)'(1);

            push_pixel(kept_row, pix, n == 1, end_frame && n == 1);
            if (has_avg)
                push_pixel(kept_row - 1, sum[PIX_W:1], n == 2, end_frame && n == 2);
            if (has_dup)
                push_pixel(kept_row + 1, pix, 1'b1, end_frame);

            prev_line[column_count] = pix;
            if (end_line) begin
                column_count = 0;
                line_count   = last_line ? 0 : line_count + 1;
            end else begin
                column_count = column_count + 1;
            end
        endfunction

        function bit frame_start();
            return column_count == 0 && line_count == 0;
        endfunction

        function int pending();
            return expected_q.size();
        endfunction

        function void compare(string name, int unsigned exp_v, int unsigned act_v);
            if (exp_v != act_v) begin
                $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, exp_v, act_v);
                errors++;
            end
        endfunction

        function void check_result(logic [31:0] data, logic last, logic done);
            frame_pixel_t e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected transfer, expected none actual data %h last %b user %b",
                         $time, data, last, done);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            compare("out_row",     e.row,    data[10:0]);
            compare("out_column",  e.column, data[22:11]);
            compare("pixel_out",   e.pix,    data[30:23]);
            compare("tdata pad",   0,        data[31]);
            compare("last_of_run", e.last,   last);
            compare("frame_done",  e.done,   done);
        endfunction
    endclass

    logic                aclk = 1'b0;
    logic                aresetn;
    logic                s_tvalid;
    logic                s_tready;
    logic [7:0]          s_tdata;
    logic                m_tvalid;
    logic                m_tready;
    logic [31:0]         m_tdata;
    logic                m_tlast;
    logic                m_tuser;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [31:0]         pwdata;
    logic [31:0]         prdata;
    logic                pready;

    deint_scoreboard sb;
    int              burst_left;
    int unsigned     pixels_sent;
    rx_mode_t        rx_mode;
    int              rx_mode_left;
    int              rx_stall_left;

    bob_deinterlace_line_average_core #(
        .MAX_LINE_LENGTH(MAX_LINE),
        .MAX_FIELD_LINES(MAX_LINES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    // every accepted pixel is predicted before any result of the same edge is checked
    always @(posedge aclk) begin
        if (aresetn) begin
            if (s_tvalid && s_tready) sb.note_pixel(s_tdata);
            if (m_tvalid && m_tready) sb.check_result(m_tdata, m_tlast, m_tuser);
        end
    end

    // receiver back-pressure: switches between always ready, random and bursty stalls
    always @(negedge aclk) begin
        if (rx_mode_left == 0) begin
            rx_mode      = rx_mode_t'($urandom_range(0, 2));
            rx_mode_left = $urandom_range(20, 120);
        end
        rx_mode_left--;
        case (rx_mode)
            RX_READY:  m_tready = 1'b1;
            RX_RANDOM: m_tready = ($urandom_range(0, 3) != 0);
            default: begin
                if (rx_stall_left > 0) begin
                    m_tready = 1'b0;
                    rx_stall_left--;
                end else begin
                    m_tready = 1'b1;
                    if ($urandom_range(0, 5) == 0) rx_stall_left = $urandom_range(1, 6);
                end
            end
        endcase
    end

    // called at a falling edge, returns at a falling edge after the transfer
    task automatic send_pixel(input logic [7:0] pix);
        s_tdata  = pix;
        s_tvalid = 1'b1;
        do @(posedge aclk); while (!s_tready);
        pixels_sent++;
        @(negedge aclk);
        burst_left--;
        if (burst_left <= 0) begin
            s_tvalid = 1'b0;
            repeat ($urandom_range(1, 6)) @(negedge aclk);
            burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                                     : $urandom_range(1, 12);
        end
    endtask

    task automatic drain();
        s_tvalid = 1'b0;
        while (sb.pending() != 0) @(negedge aclk);
        repeat (4) @(negedge aclk);
    endtask

    task automatic write_reg(input logic [1:0] index, input logic [31:0] value);
        psel    = 1'b1;
        penable = 1'b0;
        pwrite  = 1'b1;
        paddr   = {index, 2'b00};
        pwdata  = value;
        @(negedge aclk);
        penable = 1'b1;
        do @(posedge aclk); while (!pready);
        sb.write_register(index, value);
        @(negedge aclk);
        psel    = 1'b0;
        penable = 1'b0;
        pwrite  = 1'b0;
    endtask

    task automatic set_format(input int len, input int lines, input int top);
        write_reg(REG_LINE_LENGTH, len);
        write_reg(REG_FIELD_LINES, lines);
        write_reg(REG_TOP_FIELD, top);
    endtask

    function automatic logic [7:0] rand_pixel();
        case ($urandom_range(0, 7))
            0:       return 8'h00;
            1:       return 8'hFF;
            default: return 8'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic finish_frame();
        while (!sb.frame_start()) send_pixel(rand_pixel());
    endtask

    task automatic send_frame();
        do send_pixel(rand_pixel()); while (!sb.frame_start());
    endtask

    initial begin
        #10_000_000;
        $display("simulation failed");
        $finish;
    end

    initial begin
        int unsigned random_start;
        sb            = new();
        aresetn       = 1'b0;
        s_tvalid      = 1'b0;
        s_tdata       = '0;
        m_tready      = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        burst_left    = $urandom_range(1, 12);
        pixels_sent   = 0;
        rx_mode       = RX_READY;
        rx_mode_left  = 0;
        rx_stall_left = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;
        @(negedge aclk);

        // reset format: start of a long top-field line
        send_pixel(8'h00);
        send_pixel(8'hFF);
        send_pixel(8'h80);
        // shrink the line below the current column: the next pixel closes the line
        drain();
        set_format(2, 2, 1);
        send_pixel(8'h55);
        send_pixel(8'hFF);
        send_pixel(8'h01);
        // bottom field, frame cut short by lowering the line count mid-frame
        drain();
        set_format(3, 3, 0);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        send_pixel(8'hAA);
        send_pixel(8'h55);
        drain();
        write_reg(REG_FIELD_LINES, 2);
        finish_frame();
        // zero and oversized values clamp
        drain();
        set_format(0, 2047, 1);
        send_pixel(8'hFF);
        send_pixel(8'h00);
        drain();
        write_reg(REG_FIELD_LINES, 0);
        send_pixel(8'hFF);

        // oversized line length on a single-line field, then closed by a shorter line
        drain();
        set_format(8191, 1, 1);
        send_pixel(8'h12);
        send_pixel(8'hFE);
        send_pixel(8'h01);
        drain();
        write_reg(REG_LINE_LENGTH, 2);
        finish_frame();

        // random small formats, whole frames, some with a format change mid-frame
        random_start = pixels_sent;
        while (pixels_sent - random_start < 200) begin
            drain();
            set_format(($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 10),
                       ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 5),
                       $urandom_range(0, 1));
            repeat ($urandom_range(1, 3)) begin
                if ($urandom_range(0, 3) == 0) begin
                    repeat ($urandom_range(1, 8)) send_pixel(rand_pixel());
                    drain();
                    // line length only shrinks here, so the line store is always valid
                    case ($urandom_range(0, 2))
                        0:       write_reg(REG_LINE_LENGTH, $urandom_range(0, sb.line_length));
                        1:       write_reg(REG_FIELD_LINES, $urandom_range(0, 5));
                        default: write_reg(REG_TOP_FIELD, {31'b0, !sb.top_field});
                    endcase
                    finish_frame();
                end else begin
                    send_frame();
                end
            end
        end

        drain();
        repeat (10) @(posedge aclk);
        if (sb.errors == 0) begin
            $display("simulation ok");
        end else begin
            $display("simulation failed");
        end
        $finish;
    end
endmodule
